>>> rtl/dtlv_pkg.sv
// shared types, constants and the universal-form check for the der tlv header parser
`default_nettype none

package dtlv_pkg;

  localparam int unsigned MAX_TAG_OCTETS    = 4;
  localparam int unsigned MAX_LENGTH_OCTETS = 4;

  localparam int unsigned TagW      = 28;
  localparam int unsigned TagCntW   = 3;
  localparam int unsigned LenW      = 32;
  localparam int unsigned HdrW      = 4;
  localparam int unsigned LenLeftW  = $clog2(MAX_LENGTH_OCTETS + 1);

  localparam logic [7:0] HIGH_TAG_MARK   = 8'h1f;
  localparam logic [7:0] MORE_BIT        = 8'h80;
  localparam logic [7:0] INDEFINITE_LEN  = 8'h80;

  // universal tags with a fixed form
  localparam logic [TagW-1:0] UNIV_BOOLEAN     = 28'h01;
  localparam logic [TagW-1:0] UNIV_INTEGER     = 28'h02;
  localparam logic [TagW-1:0] UNIV_BIT_STRING  = 28'h03;
  localparam logic [TagW-1:0] UNIV_OCTET_STR   = 28'h04;
  localparam logic [TagW-1:0] UNIV_NULL        = 28'h05;
  localparam logic [TagW-1:0] UNIV_OID         = 28'h06;
  localparam logic [TagW-1:0] UNIV_SEQUENCE    = 28'h10;
  localparam logic [TagW-1:0] UNIV_SET         = 28'h11;
  localparam logic [TagW-1:0] UNIV_PRINTABLE   = 28'h13;
  localparam logic [TagW-1:0] UNIV_T61         = 28'h14;
  localparam logic [TagW-1:0] UNIV_IA5         = 28'h16;
  localparam logic [TagW-1:0] UNIV_UTC_TIME    = 28'h17;

  localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FORMAT  = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_SHORT   = 3'd3,
    ST_LARGE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TAG_FIRST = 3'd1,
    PH_TAG_MORE  = 3'd2,
    PH_LEN_FIRST = 3'd3,
    PH_LEN_MORE  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            start_req;
    logic [LenW-1:0] available_length;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [1:0]      tag_class;
    logic            constructed;
    logic [TagW-1:0] tag_number;
    logic [HdrW-1:0] hdr_len;
    logic [LenW-1:0] body_len;
  } out_item_t;

  typedef struct packed {
    phase_e              phase;
    logic [1:0]          class_bits;
    logic                constructed_bit;
    logic [TagW-1:0]     tag_acc;
    logic [TagCntW-1:0]  tag_cnt;
    logic [LenW-1:0]     len_acc;
    logic [LenLeftW-1:0] len_left;
    logic [HdrW-1:0]     consumed;
    logic [LenW-1:0]     avail;
  } dec_state_t;

  // true when a universal tag carries the wrong primitive/constructed form
  function automatic logic bad_universal_form(logic [1:0] cls, logic cons,
                                              logic [TagW-1:0] tag);
    logic bad;
    bad = 1'b0;
    if (cls == CLASS_UNIVERSAL) begin
      case (tag)
        UNIV_BOOLEAN, UNIV_INTEGER, UNIV_BIT_STRING, UNIV_OCTET_STR,
        UNIV_NULL, UNIV_OID, UNIV_PRINTABLE, UNIV_T61, UNIV_IA5,
        UNIV_UTC_TIME: bad = cons;
        UNIV_SEQUENCE, UNIV_SET: bad = !cons;
        default: bad = 1'b0;
      endcase
    end
    return bad;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dtlv_decode.sv
// per-byte header decode: state registers and the combinational step
`default_nettype none

module dtlv_decode (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fire_i,
  input  dtlv_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output dtlv_pkg::out_item_t res_o
);
  import dtlv_pkg::*;

  localparam logic [TagCntW:0] MaxTagOcts = (TagCntW + 1)'(MAX_TAG_OCTETS);
  localparam logic [6:0]       MaxLenOcts = 7'(MAX_LENGTH_OCTETS);

  dec_state_t st_q, st_d;

  logic [7:0]      b;
  logic [HdrW-1:0] consumed_inc;
  logic [TagW-1:0] tag_next;
  logic [LenW-1:0] len_next;
  logic [LenW-1:0] body_cand;
  logic            fits;
  logic            err;
  status_e         err_code;
  logic            done_ok;

  assign b            = item_i.data_byte;
  assign consumed_inc = st_q.consumed + 1'b1;
  assign tag_next     = {st_q.tag_acc[TagW-8:0], b[6:0]};
  assign len_next     = {st_q.len_acc[LenW-9:0], b};
  assign body_cand    = (st_q.phase == PH_LEN_FIRST) ? {25'd0, b[6:0]} : len_next;
  assign fits = ({29'd0, consumed_inc} + {1'b0, body_cand}) <= {1'b0, st_q.avail};

  always_comb begin
    st_d     = st_q;
    err      = 1'b0;
    err_code = ST_OK;
    done_ok  = 1'b0;
    if (item_i.start_req) begin
      st_d.avail           = item_i.available_length;
      st_d.class_bits      = b[7:6];
      st_d.constructed_bit = b[5];
      st_d.tag_acc         = {23'd0, b[4:0]};
      st_d.tag_cnt         = '0;
      st_d.len_acc         = '0;
      st_d.len_left        = '0;
      st_d.consumed        = HdrW'(1);
      if (item_i.available_length < 32'd2) begin
        err      = 1'b1;
        err_code = ST_SHORT;
      end else if (b[4:0] == HIGH_TAG_MARK[4:0]) begin
        st_d.tag_acc = '0;
        st_d.phase   = PH_TAG_FIRST;
      end else if (bad_universal_form(b[7:6], b[5], {23'd0, b[4:0]})) begin
        err      = 1'b1;
        err_code = ST_FORMAT;
      end else begin
        st_d.phase = PH_LEN_FIRST;
      end
    end else if (st_q.phase != PH_IDLE) begin
      if ({28'd0, st_q.consumed} >= st_q.avail) begin
        err      = 1'b1;
        err_code = ST_OVERRUN;
      end else begin
        case (st_q.phase)
          PH_TAG_FIRST, PH_TAG_MORE: begin
            if (st_q.phase == PH_TAG_FIRST && b < HIGH_TAG_MARK) begin
              err      = 1'b1;
              err_code = ST_FORMAT;
            end else if (st_q.tag_acc == '0 && b == MORE_BIT) begin
              err      = 1'b1;
              err_code = ST_FORMAT;
            end else if ({1'b0, st_q.tag_cnt} >= MaxTagOcts ||
                         st_q.tag_acc[TagW-1:TagW-7] != '0) begin
              err      = 1'b1;
              err_code = ST_LARGE;
            end else begin
              st_d.tag_acc  = tag_next;
              st_d.tag_cnt  = st_q.tag_cnt + 1'b1;
              st_d.consumed = consumed_inc;
              if (b[7]) begin
                st_d.phase = PH_TAG_MORE;
              end else if (bad_universal_form(st_q.class_bits, st_q.constructed_bit,
                                              tag_next)) begin
                err      = 1'b1;
                err_code = ST_FORMAT;
              end else begin
                st_d.phase = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            st_d.consumed = consumed_inc;
            if (b == INDEFINITE_LEN) begin
              err      = 1'b1;
              err_code = ST_FORMAT;
            end else if (!b[7]) begin
              done_ok = 1'b1;
            end else if (b[6:0] > MaxLenOcts) begin
              err      = 1'b1;
              err_code = ST_LARGE;
            end else begin
              st_d.len_left = b[LenLeftW-1:0];
              st_d.len_acc  = '0;
              st_d.phase    = PH_LEN_MORE;
            end
          end
          PH_LEN_MORE: begin
            if (st_q.len_acc == '0 && b == 8'd0) begin
              err      = 1'b1;
              err_code = ST_FORMAT;
            end else if (st_q.len_acc[LenW-1:LenW-8] != '0) begin
              err      = 1'b1;
              err_code = ST_LARGE;
            end else begin
              st_d.len_acc  = len_next;
              st_d.consumed = consumed_inc;
              st_d.len_left = st_q.len_left - 1'b1;
              if (st_d.len_left == '0) begin
                if (len_next < 32'h80) begin
                  err      = 1'b1;
                  err_code = ST_FORMAT;
                end else begin
                  done_ok = 1'b1;
                end
              end
            end
          end
          default: st_d.phase = PH_IDLE;
        endcase
      end
    end
    // a header whose length plus body does not fit the available bytes is an overrun
    if (done_ok && !fits) begin
      done_ok  = 1'b0;
      err      = 1'b1;
      err_code = ST_OVERRUN;
    end
    if (err || done_ok) begin
      st_d.phase = PH_IDLE;
    end
  end

  always_comb begin
    res_valid_o = err || done_ok;
    res_o       = '0;
    if (err) begin
      res_o.status = err_code;
    end else if (done_ok) begin
      res_o.status      = ST_OK;
      res_o.tag_class   = st_q.class_bits;
      res_o.constructed = st_q.constructed_bit;
      res_o.tag_number  = st_q.tag_acc;
      res_o.hdr_len     = consumed_inc;
      res_o.body_len    = body_cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, default: '0};
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |->
      (res_o.tag_number == '0 && res_o.body_len == '0 && res_o.hdr_len == '0))
    else $error("error item carries decoded fields");

  a_ok_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_OK) |->
      (res_o.hdr_len >= HdrW'(2) && res_o.hdr_len <= HdrW'(10)))
    else $error("header length out of range");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_valid_o) |=> (st_q.phase == PH_IDLE))
    else $error("decoder not idle after a result");

endmodule

`default_nettype wire

>>> rtl/dtlv_out_buf.sv
// two-entry result buffer: output register plus skid stage
`default_nettype none

module dtlv_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  dtlv_pkg::out_item_t item_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output dtlv_pkg::out_item_t out_item_o
);
  import dtlv_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = item_i;
      end else begin
        out_valid_d = push_i;
        out_d       = item_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = item_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !pop) |-> !push_i)
    else $error("item pushed into a full buffer");

  a_stalled_push_skids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !pop) |=> skid_valid_q)
    else $error("item lost behind a stalled output");

endmodule

`default_nettype wire

>>> rtl/der_tlv_header_parser.sv
// top level of the der tlv header parser
// Usage:
//   in channel: one byte of the header stream per item on in_item_i, with
//   start_req set on the identifier byte of each header; available_length
//   is taken from that start item. An item is taken at a clock edge where
//   in_valid_i is high and in_stall_o is low.
//   out channel: one item per finished or failed header, either the decoded fields (status ok)
//   or an error status with all other fields zero. Taken where out_valid_o
//   is high and out_stall_i is low.
// Result path: the result is decoded combinationally from the byte that completes the
//   header or shows it to be bad, then registered into the output register or the skid stage.
// Throughput: one byte per cycle while in_stall_o is low; the decode of each byte is a
//   shift-add and a few compares on the registered decoder state.
// Stall: results collect in an output register and a skid stage; in_stall_o
//   rises only once both hold an item, so bytes keep flowing while one
//   result waits.
// Reset: clears the decoder to idle and empties both result stages; bytes
//   without start_req are ignored until a start arrives.
`default_nettype none

module der_tlv_header_parser (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  dtlv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output dtlv_pkg::out_item_t out_item_o
);
  import dtlv_pkg::*;

  logic      fire;
  logic      res_valid;
  out_item_t res;
  logic      buf_full;

  assign in_stall_o = buf_full;
  assign fire       = in_valid_i && !buf_full;

  dtlv_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dtlv_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && res_valid),
    .item_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_der_tlv_header_parser.sv
// self-checking testbench for the der tlv header parser: directed and random byte streams
`timescale 1ns / 100ps

module tb_der_tlv_header_parser;
  import dtlv_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  der_tlv_header_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t    pending_items[$];
  out_item_t   expected_hdrs[$];
  logic [7:0]  hdr_buf[$];
  int          total_bytes = 0;
  int          header_bytes = 0;
  int          items_sent = 0;
  int          fails = 0;
  int          status_seen[5] = '{default: 0};
  int          input_stall_cycles = 0;
  int          gap_left = 0;
  logic        no_idle_q = 1'b0;

  // decoder state as predicted from the accepted bytes
  phase_e      dec_phase = PH_IDLE;
  logic [1:0]  cur_class = '0;
  logic        cur_cons = 1'b0;
  logic [27:0] tag_acc = '0;
  int          tag_cnt = 0;
  logic [31:0] len_acc = '0;
  int          len_left = 0;
  logic [3:0]  consumed = '0;
  logic [31:0] avail = '0;

  function automatic bit univ_form_wrong(logic [1:0] cls, logic cons, logic [27:0] tag);
    if (cls != CLASS_UNIVERSAL) return 1'b0;
    case (tag)
      UNIV_BOOLEAN, UNIV_INTEGER, UNIV_BIT_STRING, UNIV_OCTET_STR, UNIV_NULL, UNIV_OID,
      UNIV_PRINTABLE, UNIV_T61, UNIV_IA5, UNIV_UTC_TIME: return cons;
      UNIV_SEQUENCE, UNIV_SET: return !cons;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_error(status_e code);
    out_item_t r;
    r = '0;
    r.status = code;
    expected_hdrs.push_back(r);
    dec_phase = PH_IDLE;
  endtask

  task automatic report_header(logic [31:0] body);
    out_item_t r;
    if (64'(consumed) + 64'(body) > 64'(avail)) begin
      report_error(ST_OVERRUN);
    end else begin
      r.status      = ST_OK;
      r.tag_class   = cur_class;
      r.constructed = cur_cons;
      r.tag_number  = tag_acc;
      r.hdr_len     = consumed;
      r.body_len    = body;
      expected_hdrs.push_back(r);
      dec_phase = PH_IDLE;
    end
  endtask

  task automatic decode_byte(in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    if (it.start_req) begin
      avail     = it.available_length;
      cur_class = b[7:6];
      cur_cons  = b[5];
      tag_acc   = {23'd0, b[4:0]};
      tag_cnt   = 0;
      len_acc   = '0;
      len_left  = 0;
      consumed  = 4'd1;
      if (avail < 32'd2) begin
        report_error(ST_SHORT);
      end else if (b[4:0] == HIGH_TAG_MARK[4:0]) begin
        tag_acc   = '0;
        dec_phase = PH_TAG_FIRST;
      end else if (univ_form_wrong(cur_class, cur_cons, tag_acc)) begin
        report_error(ST_FORMAT);
      end else begin
        dec_phase = PH_LEN_FIRST;
      end
    end else if (dec_phase != PH_IDLE) begin
      if (32'(consumed) >= avail) begin
        report_error(ST_OVERRUN);
      end else begin
        case (dec_phase)
          PH_TAG_FIRST, PH_TAG_MORE: begin
            if (dec_phase == PH_TAG_FIRST && b < HIGH_TAG_MARK) begin
              report_error(ST_FORMAT);
            end else if (tag_acc == '0 && b == MORE_BIT) begin
              report_error(ST_FORMAT);
            end else if (tag_cnt >= MAX_TAG_OCTETS || tag_acc[27:21] != '0) begin
              report_error(ST_LARGE);
            end else begin
              tag_acc  = {tag_acc[20:0], b[6:0]};
              tag_cnt++;
              consumed = consumed + 4'd1;
              if (b[7]) begin
                dec_phase = PH_TAG_MORE;
              end else if (univ_form_wrong(cur_class, cur_cons, tag_acc)) begin
                report_error(ST_FORMAT);
              end else begin
                dec_phase = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            consumed = consumed + 4'd1;
            if (b == INDEFINITE_LEN) begin
              report_error(ST_FORMAT);
            end else if (!b[7]) begin
              report_header({24'd0, b});
            end else if (b[6:0] > MAX_LENGTH_OCTETS) begin
              report_error(ST_LARGE);
            end else begin
              len_left  = b[6:0];
              len_acc   = '0;
              dec_phase = PH_LEN_MORE;
            end
          end
          default: begin
            if (len_acc == '0 && b == 8'h00) begin
              report_error(ST_FORMAT);
            end else if (len_acc[31:24] != '0) begin
              report_error(ST_LARGE);
            end else begin
              len_acc  = {len_acc[23:0], b};
              consumed = consumed + 4'd1;
              len_left--;
              if (len_left == 0) begin
                if (len_acc < 32'h80) begin
                  report_error(ST_FORMAT);
                end else begin
                  report_header(len_acc);
                end
              end
            end
          end
        endcase
      end
    end
  endtask

  // stimulus building: hdr_buf holds the bytes of one header under construction
  task automatic build_header(logic [1:0] cls, logic cons, logic [27:0] tag, logic [31:0] body);
    int n;
    hdr_buf.delete();
    if (tag < 28'd31) begin
      hdr_buf.push_back({cls, cons, tag[4:0]});
    end else begin
      hdr_buf.push_back({cls, cons, HIGH_TAG_MARK[4:0]});
      n = 1;
      while (n < 4 && (tag >> (7 * n)) != '0) n++;
      for (int i = n - 1; i >= 0; i--) hdr_buf.push_back({i != 0, tag[7 * i +: 7]});
    end
    if (body < 32'd128) begin
      hdr_buf.push_back(body[7:0]);
    end else begin
      n = 1;
      while (n < 4 && (body >> (8 * n)) != '0) n++;
      hdr_buf.push_back(8'h80 | 8'(n));
      for (int i = n - 1; i >= 0; i--) hdr_buf.push_back(body[8 * i +: 8]);
    end
  endtask

  task automatic send_buf(logic [31:0] avail_len, int keep);
    in_item_t it;
    for (int i = 0; i < keep; i++) begin
      it.data_byte        = hdr_buf[i];
      it.start_req        = (i == 0);
      it.available_length = (i == 0) ? avail_len : $urandom;
      pending_items.push_back(it);
    end
    header_bytes += keep;
  endtask

  // bytes with no start: ignored while idle or after an error
  task automatic send_noise(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it.data_byte        = 8'($urandom);
      it.start_req        = 1'b0;
      it.available_length = $urandom;
      pending_items.push_back(it);
    end
  endtask

  task automatic build_random_header(output logic [31:0] body);
    logic [1:0]  cls;
    logic        cons;
    logic [27:0] tag;
    int          k;
    cls  = 2'($urandom);
    cons = 1'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      tag = 28'($urandom_range(0, 30));
    end else begin
      k   = $urandom_range(1, 4);
      tag = 28'($urandom_range(k == 1 ? 31 : 1 << (7 * (k - 1)), (1 << (7 * k)) - 1));
    end
    if (univ_form_wrong(cls, cons, tag)) cons = !cons;
    case ($urandom_range(0, 7))
      1: body = $urandom_range(128, 255);
      2: body = $urandom_range(256, 32'h0000_ffff);
      3: body = $urandom_range(32'h0001_0000, 32'h00ff_ffff);
      4: body = $urandom_range(32'h0100_0000, 32'hffff_ffff);
      default: body = $urandom_range(0, 127);
    endcase
    build_header(cls, cons, tag, body);
  endtask

  task automatic random_header();
    logic [31:0] body;
    logic [31:0] avail_len;
    logic [63:0] total;
    logic [63:0] sum;
    build_random_header(body);
    total = 64'(hdr_buf.size()) + 64'(body);
    if (total > 64'hffff_ffff) total = 64'hffff_ffff;
    case ($urandom_range(0, 9))
      0: avail_len = $urandom_range(2, 32'(total - 1));
      1: avail_len = $urandom;
      default: begin
        sum       = total + 64'($urandom_range(0, 3));
        avail_len = (sum > 64'hffff_ffff) ? 32'hffff_ffff : 32'(sum);
      end
    endcase
    send_buf(avail_len, hdr_buf.size());
  endtask

  task automatic broken_header();
    logic [27:0] fixed_tags [12];
    logic [31:0] body;
    logic [31:0] avail_len;
    logic [27:0] t;
    logic [7:0]  lead;
    logic [7:0]  ident;
    int          m;
    fixed_tags = '{UNIV_BOOLEAN, UNIV_INTEGER, UNIV_BIT_STRING, UNIV_OCTET_STR, UNIV_NULL,
                   UNIV_OID, UNIV_SEQUENCE, UNIV_SET, UNIV_PRINTABLE, UNIV_T61, UNIV_IA5,
                   UNIV_UTC_TIME};
    lead      = {2'($urandom), 1'($urandom), HIGH_TAG_MARK[4:0]};
    ident     = {2'b10, 1'($urandom), 5'($urandom_range(0, 30))};
    avail_len = $urandom_range(16, 32'hffff_ffff);
    case ($urandom_range(0, 10))
      0: begin
        // header cut short; the next start drops it
        build_random_header(body);
        send_buf(32'hffff_ffff, $urandom_range(1, hdr_buf.size() - 1));
        return;
      end
      1: begin
        build_random_header(body);
        avail_len = $urandom_range(0, 1);
      end
      2: hdr_buf = '{lead, 8'($urandom_range(0, 30)), 8'h00};
      3: hdr_buf = '{lead, MORE_BIT, 8'h01, 8'h00};
      4: begin
        hdr_buf = '{lead};
        for (int i = 0; i < MAX_TAG_OCTETS; i++) hdr_buf.push_back(8'($urandom_range(8'h81, 8'hff)));
        hdr_buf.push_back(8'($urandom));
        hdr_buf.push_back(8'h00);
      end
      5: begin
        t = fixed_tags[$urandom_range(0, 11)];
        hdr_buf = '{{CLASS_UNIVERSAL, !univ_form_wrong(CLASS_UNIVERSAL, 1'b0, t), t[4:0]}, 8'h00};
      end
      6: hdr_buf = '{ident, INDEFINITE_LEN};
      7: hdr_buf = '{ident, 8'h80 | 8'($urandom_range(MAX_LENGTH_OCTETS + 1, 127))};
      8: begin
        m = $urandom_range(2, MAX_LENGTH_OCTETS);
        hdr_buf = '{ident, 8'h80 | 8'(m), 8'h00, 8'($urandom)};
      end
      9: hdr_buf = '{ident, 8'h81, 8'($urandom_range(1, 127))};
      default: begin
        hdr_buf.delete();
        m = $urandom_range(1, 6);
        for (int i = 0; i < m; i++) hdr_buf.push_back(8'($urandom));
        avail_len = $urandom;
      end
    endcase
    send_buf(avail_len, hdr_buf.size());
    send_noise($urandom_range(0, 3));
  endtask

  // sender: offers queued items with random gaps, holding each until taken
  always @(posedge clk_i) begin : drive
    bit took;
    bit no_idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        decode_byte(in_item_i);
        items_sent++;
      end
      if (in_valid_i && in_stall_o) input_stall_cycles++;
      // no idling in the tail, nor in every third stretch
      no_idle = (items_sent + 150 >= total_bytes) || ((items_sent / 200) % 3 == 1);
      no_idle_q <= no_idle;
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid_i <= 1'b0;
        end else begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back the block up
  int rx_cycles = 0;
  int holdoff_left = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 1200) holdoff_left = 250;
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!no_idle_q && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hdrs.size() == 0) begin
        $error("result with none pending: status %0d tag %0h", out_item_o.status,
               out_item_o.tag_number);
        fails++;
      end else begin
        want = expected_hdrs.pop_front();
        if (want.status <= ST_LARGE) status_seen[want.status]++;
        check_field("status", want.status, out_item_o.status);
        check_field("tag_class", want.tag_class, out_item_o.tag_class);
        check_field("constructed", want.constructed, out_item_o.constructed);
        check_field("tag_number", want.tag_number, out_item_o.tag_number);
        check_field("hdr_len", want.hdr_len, out_item_o.hdr_len);
        check_field("body_len", want.body_len, out_item_o.body_len);
      end
    end
  end

  initial begin
    int waited;
    // a stray byte before any start
    hdr_buf = '{8'hff};
    send_noise(1);
    // available below two, both values
    hdr_buf = '{8'h30};
    send_buf(32'd0, 1);
    hdr_buf = '{8'hff};
    send_buf(32'd1, 1);
    // integer with exactly enough bytes
    hdr_buf = '{8'h02, 8'h01};
    send_buf(32'd3, 2);
    // sequence sent as primitive
    hdr_buf = '{8'h10};
    send_buf(32'd9, 1);
    // restart in the middle of a header, then a minimal private header
    hdr_buf = '{8'h30};
    send_buf(32'd100, 1);
    hdr_buf = '{8'hc0, 8'h00};
    send_buf(32'd2, 2);
    // high form used for a small tag, and a leading zero tag octet
    hdr_buf = '{8'hdf, 8'h05};
    send_buf(32'd9, 2);
    hdr_buf = '{8'h5f, MORE_BIT};
    send_buf(32'd9, 2);
    // one tag octet too many
    hdr_buf = '{8'h3f, 8'h81, 8'h82, 8'h83, 8'h84, 8'h05};
    send_buf(32'd20, 6);
    // indefinite, too many length octets, leading zero, short value in long form
    hdr_buf = '{8'h04, INDEFINITE_LEN};
    send_buf(32'd9, 2);
    hdr_buf = '{8'h04, 8'h85};
    send_buf(32'd9, 2);
    hdr_buf = '{8'h04, 8'h82, 8'h00};
    send_buf(32'd9, 3);
    hdr_buf = '{8'h04, 8'h81, 8'h7f};
    send_buf(32'd9, 3);
    // a length byte past the available count, and a body that does not fit
    hdr_buf = '{8'h30, 8'h81, 8'hff};
    send_buf(32'd2, 3);
    hdr_buf = '{8'h04, 8'h05};
    send_buf(32'd6, 2);
    // largest tag, four length octets, filling the whole 32-bit range
    build_header(2'b11, 1'b1, 28'h0fff_ffff, 32'hffff_fff5);
    send_buf(32'hffff_ffff, hdr_buf.size());

    while (pending_items.size() < 1800) begin
      if ($urandom_range(0, 9) < 7) begin
        random_header();
      end else begin
        broken_header();
      end
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
    end
    total_bytes = pending_items.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (items_sent == total_bytes);
    waited = 0;
    while (expected_hdrs.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    // leave room for any stray result before the final check
    repeat (20) @(posedge clk_i);
    if (expected_hdrs.size() != 0) begin
      $error("%0d results never arrived", expected_hdrs.size());
      fails++;
    end
    $display("run: %0d bytes in (%0d header bytes), results ok %0d, format %0d, overrun %0d",
             total_bytes, header_bytes, status_seen[ST_OK], status_seen[ST_FORMAT],
             status_seen[ST_OVERRUN]);
    $display("short %0d, large %0d, input held back by the block for %0d cycles",
             status_seen[ST_SHORT], status_seen[ST_LARGE], input_stall_cycles);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d of %0d bytes taken", items_sent, total_bytes);
    $display("Some tests failed");
    $finish;
  end

endmodule
